/* rtl/dal_pkg.sv */
// Package: shared types and constants of the device allow list table.
`timescale 1ns / 1ps

package dal_pkg;

   localparam int SERIAL_BYTES = 16;
   localparam logic [31:0] GEN_LIMIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_INVALID   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_EXHAUSTED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CLEAR,
      S_READ_CAP,
      S_DONE
   } fsm_type;

   typedef struct packed {
      cmd_type     command;
      logic [63:0] serial_high;
      logic [63:0] serial_low;
      logic [47:0] station_mac;
      logic [3:0]  read_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [4:0]  entry_count;
      logic [31:0] generation;
      logic [63:0] entry_serial_high;
      logic [63:0] entry_serial_low;
      logic [47:0] entry_mac;
   } rsp_type;

   typedef struct packed {
      logic [63:0] serial_high;
      logic [63:0] serial_low;
      logic [47:0] mac;
   } entry_type;

endpackage

/* rtl/dal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/device_allow_list_table.sv */
// Top level: device allow list table with a RAM-held packed entry list.
`timescale 1ns / 1ps

// Allow list of up to MAX_ENTRIES devices, each a zero-padded serial of up to
// SERIAL_CHARS characters plus a station MAC, kept packed in one entry RAM.
// One command is worked on at a time; req_ready is high while the table is
// idle, and a new word is taken while the previous response still waits on
// rsp. Entries are visited through the single RAM read port in two steps
// each (address, then compare on the registered data). Lookup and add scan
// the held entries and stop early on a hit; remove searches up to the hit,
// then shifts each later entry down by one slot (read, then write) and ends
// with one clear step that zeroes the old last slot; read fetches the
// indexed entry and captures it. No clearing pass is needed after reset:
// slots at or above the held count are never read.
module device_allow_list_table
   import dal_pkg::*;
#(
   parameter int MAX_ENTRIES  = 16,
   parameter int SERIAL_CHARS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;
   localparam int EW   = $bits(entry_type);

   fsm_type     fsm_ff, fsm_in;
   cmd_type     cmd_ff, cmd_in;
   entry_type   key_ff, key_in;
   logic [3:0]  idx_ff, idx_in;
   logic        bad_ff, bad_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] gen_ff, gen_in;
   logic [CW-1:0] scan_ff, scan_in;
   status_type  status_ff, status_in;
   logic        found_ff, found_in;
   entry_type   data_ff, data_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   entry_type     ram_wr_data, ram_rd_data;
   logic [EW-1:0] ram_rd_bits;

   // serial normalization: keep bytes up to the first zero character
   logic [SERIAL_BYTES-1:0] nz;
   logic [SERIAL_BYTES:0]   keep;
   logic [127:0]            serial_raw, serial_cut;

   logic scan_end, key_hit, gen_full, table_full, idx_ok, out_free;

   always_comb begin
      serial_raw = {req_word.serial_high, req_word.serial_low};
      for (int k = 0; k < SERIAL_BYTES; k++) begin
         nz[k] = serial_raw[127 - 8*k -: 8] != 8'd0;
      end
      keep = '0;
      for (int k = 0; k < SERIAL_BYTES; k++) begin
         keep[k] = 1'b1;
         for (int j = 0; j <= k; j++) begin
            keep[k] = keep[k] & nz[j];
         end
      end
      for (int k = 0; k < SERIAL_BYTES; k++) begin
         serial_cut[127 - 8*k -: 8] = keep[k] ? serial_raw[127 - 8*k -: 8] : 8'd0;
      end
   end

   assign ram_rd_data = entry_type'(ram_rd_bits);
   assign scan_end    = scan_ff == count_ff;
   assign key_hit     = ram_rd_data == key_ff;
   assign gen_full    = gen_ff == GEN_LIMIT;
   assign table_full  = count_ff == CW'(MAX_ENTRIES);
   assign idx_ok      = CMPW'(idx_ff) < CMPW'(count_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         S_IDLE: begin
            if (req_valid) fsm_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (cmd_ff == CMD_READ) begin
               fsm_in = idx_ok ? S_READ_CAP : S_DONE;
            end else if (cmd_ff == CMD_ADD && bad_ff) begin
               fsm_in = S_DONE;
            end else begin
               fsm_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            fsm_in = scan_end ? S_DONE : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (!key_hit) begin
               fsm_in = S_SCAN_RD;
            end else if (cmd_ff == CMD_REMOVE && !gen_full) begin
               fsm_in = S_SHIFT_RD;
            end else begin
               fsm_in = S_DONE;
            end
         end
         S_SHIFT_RD: begin
            fsm_in = scan_end ? S_CLEAR : S_SHIFT_WR;
         end
         S_SHIFT_WR: fsm_in = S_SHIFT_RD;
         S_CLEAR:    fsm_in = S_DONE;
         S_READ_CAP: fsm_in = S_DONE;
         S_DONE: begin
            if (out_free) fsm_in = S_IDLE;
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      bad_in       = bad_ff;
      count_in     = count_ff;
      gen_in       = gen_ff;
      scan_in      = scan_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      data_in      = data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = scan_ff[AW-1:0];
      ram_wr_data  = key_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[AW-1:0];
      req_ready    = 1'b0;

      unique case (fsm_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in      = req_word.command;
               key_in      = '{serial_high: serial_cut[127:64],
                               serial_low:  serial_cut[63:0],
                               mac:         req_word.station_mac};
               idx_in      = req_word.read_index;
               bad_in      = !nz[0] || keep[SERIAL_CHARS];
               scan_in     = '0;
               status_in   = STATUS_OK;
               found_in    = 1'b0;
               data_in     = '0;
            end
         end
         S_DISPATCH: begin
            if (cmd_ff == CMD_READ) begin
               if (idx_ok) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(idx_ff);
               end else begin
                  status_in = STATUS_INVALID;
               end
            end else if (cmd_ff == CMD_ADD && bad_ff) begin
               status_in = STATUS_INVALID;
            end
         end
         S_SCAN_RD: begin
            if (!scan_end) begin
               ram_rd_en = 1'b1;
            end else if (cmd_ff == CMD_REMOVE) begin
               status_in = STATUS_NOT_FOUND;
            end else if (cmd_ff == CMD_ADD) begin
               if (table_full) begin
                  status_in = STATUS_FULL;
               end else if (gen_full) begin
                  status_in = STATUS_EXHAUSTED;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[AW-1:0];
                  count_in    = count_ff + CW'(1);
                  gen_in      = gen_ff + 32'd1;
               end
            end
         end
         S_SCAN_CMP: begin
            scan_in = scan_ff + CW'(1);
            if (key_hit) begin
               if (cmd_ff == CMD_REMOVE) begin
                  if (gen_full) status_in = STATUS_EXHAUSTED;
               end else begin
                  found_in = 1'b1;
               end
            end
         end
         S_SHIFT_RD: begin
            if (!scan_end) ram_rd_en = 1'b1;
         end
         S_SHIFT_WR: begin
            // read and write never target one slot in the same cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(scan_ff - CW'(1));
            ram_wr_data = ram_rd_data;
            scan_in     = scan_ff + CW'(1);
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(count_ff - CW'(1));
            ram_wr_data = '0;
            count_in    = count_ff - CW'(1);
            gen_in      = gen_ff + 32'd1;
         end
         S_READ_CAP: begin
            data_in = ram_rd_data;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status:            status_ff,
                                found:             found_ff,
                                entry_count:       5'(count_ff),
                                generation:        gen_ff,
                                entry_serial_high: data_ff.serial_high,
                                entry_serial_low:  data_ff.serial_low,
                                entry_mac:         data_ff.mac};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         gen_ff       <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      bad_ff    <= bad_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

   dal_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* dv/tb_device_allow_list_table.sv */
// Testbench: device allow list table, predicted table state checked on every response word.
`timescale 1ns / 1ps

module tb_device_allow_list_table;
   import dal_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int KEY_COUNT    = 24;
   localparam int RANDOM_WORDS = 600;
   localparam int SETTLE_WAIT  = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   // both sides run with no idling while this is set
   bit          no_idle = 1'b0;
   int          stall_left = 0;
   int          stall_pick;
   entry_type   dev_key [KEY_COUNT];
   int          dev_len [KEY_COUNT];

   // Mirror of the allow list; predicts one response word per request word.
   class allow_list_tracker;
      logic [63:0] serial_hi [TABLE_DEPTH];
      logic [63:0] serial_lo [TABLE_DEPTH];
      logic [47:0] mac_at    [TABLE_DEPTH];
      int          held;
      logic [31:0] gen_count;
      rsp_type     awaited [$];
      int          mismatches;

      function new();
         held       = 0;
         gen_count  = '0;
         mismatches = 0;
         foreach (serial_hi[i]) begin
            serial_hi[i] = '0;
            serial_lo[i] = '0;
            mac_at[i]    = '0;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Serial ends at its first zero character; everything behind it is cleared.
      function int trim_serial(inout logic [63:0] hi, inout logic [63:0] lo);
         logic [127:0] s;
         int           n;
         s = {hi, lo};
         n = 0;
         while (n < SERIAL_BYTES && s[127 - 8*n -: 8] != 8'h00) n++;
         for (int k = n; k < SERIAL_BYTES; k++) s[127 - 8*k -: 8] = 8'h00;
         hi = s[127:64];
         lo = s[63:0];
         return n;
      endfunction

      function int locate(logic [63:0] hi, logic [63:0] lo, logic [47:0] mac);
         for (int i = 0; i < held; i++) begin
            if (serial_hi[i] == hi && serial_lo[i] == lo && mac_at[i] == mac) return i;
         end
         return -1;
      endfunction

      function void predict_command(req_type w);
         rsp_type     r;
         logic [63:0] hi;
         logic [63:0] lo;
         logic [47:0] mac;
         int          n;
         int          pos;
         hi  = w.serial_high;
         lo  = w.serial_low;
         mac = w.station_mac;
         n   = trim_serial(hi, lo);
         r   = '0;
         r.status = STATUS_OK;
         case (w.command)
            CMD_LOOKUP: begin
               r.found = (locate(hi, lo, mac) >= 0);
            end
            CMD_ADD: begin
               if (n == 0) begin
                  r.status = STATUS_INVALID;
               end else if (locate(hi, lo, mac) >= 0) begin
                  r.found = 1'b1;
               end else if (held >= TABLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else if (gen_count == GEN_LIMIT) begin
                  r.status = STATUS_EXHAUSTED;
               end else begin
                  serial_hi[held] = hi;
                  serial_lo[held] = lo;
                  mac_at[held]    = mac;
                  held++;
                  gen_count++;
               end
            end
            CMD_REMOVE: begin
               pos = locate(hi, lo, mac);
               if (pos < 0) begin
                  r.status = STATUS_NOT_FOUND;
               end else if (gen_count == GEN_LIMIT) begin
                  r.status = STATUS_EXHAUSTED;
               end else begin
                  for (int i = pos + 1; i < held; i++) begin
                     serial_hi[i-1] = serial_hi[i];
                     serial_lo[i-1] = serial_lo[i];
                     mac_at[i-1]    = mac_at[i];
                  end
                  held--;
                  serial_hi[held] = '0;
                  serial_lo[held] = '0;
                  mac_at[held]    = '0;
                  gen_count++;
               end
            end
            default: begin
               if (int'(w.read_index) < held) begin
                  r.entry_serial_high = serial_hi[w.read_index];
                  r.entry_serial_low  = serial_lo[w.read_index];
                  r.entry_mac         = mac_at[w.read_index];
               end else begin
                  r.status = STATUS_INVALID;
               end
            end
         endcase
         r.entry_count = 5'(held);
         r.generation  = gen_count;
         awaited.push_back(r);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) flag($sformatf("%s expected %h, got %h", name, want, got));
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            flag($sformatf("response word with none outstanding: %h", got));
            return;
         end
         want = awaited.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("found", 64'(want.found), 64'(got.found));
         compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
         compare_field("generation", 64'(want.generation), 64'(got.generation));
         compare_field("entry_serial_high", want.entry_serial_high, got.entry_serial_high);
         compare_field("entry_serial_low", want.entry_serial_low, got.entry_serial_low);
         compare_field("entry_mac", 64'(want.entry_mac), 64'(got.entry_mac));
      endfunction
   endclass

   allow_list_tracker tracker;

   device_allow_list_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int gap_cycles();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_ready <= !reset;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         stall_pick = ($urandom_range(0, 3) == 0) ? gap_cycles() : 0;
         rsp_ready <= (stall_pick == 0);
         stall_left = (stall_pick > 0) ? stall_pick - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.predict_command(req_word);
         if (rsp_valid && rsp_ready) tracker.check_reply(rsp_word);
      end
   end

   task automatic send_word(req_type w);
      int gap;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // the first edge lets the monitor log the last accepted word
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic build_keys();
      logic [127:0] s;
      for (int k = 0; k < KEY_COUNT; k++) begin
         dev_len[k] = (k == 2) ? 1 : (k == 3) ? 8 : (k == 4) ? 9 :
                      $urandom_range(1, SERIAL_BYTES);
         s = '0;
         for (int p = 0; p < dev_len[k]; p++) s[127 - 8*p -: 8] = 8'($urandom_range(1, 255));
         dev_key[k] = {s, 48'({$urandom, $urandom})};
      end
      // all-ones serial and MAC, then the same serial with a zero MAC
      dev_len[0] = SERIAL_BYTES;
      dev_key[0] = {{SERIAL_BYTES{8'hFF}}, {48{1'b1}}};
      dev_len[1] = SERIAL_BYTES;
      dev_key[1] = {dev_key[0].serial_high, dev_key[0].serial_low, 48'h0};
      // differs from key 4 only in the first character of the low word
      dev_len[5] = 9;
      dev_key[5] = dev_key[4];
      dev_key[5].serial_low[63:56] = (dev_key[4].serial_low[63:56] == 8'h41) ? 8'h42 : 8'h41;
   endtask

   function automatic req_type key_word(cmd_type c, int k, bit junk);
      req_type      w;
      logic [127:0] s;
      s = {dev_key[k].serial_high, dev_key[k].serial_low};
      // bytes behind the terminating zero must not matter
      if (junk) begin
         for (int p = dev_len[k] + 1; p < SERIAL_BYTES; p++) s[127 - 8*p -: 8] = 8'($urandom);
      end
      w.command     = c;
      w.serial_high = s[127:64];
      w.serial_low  = s[63:0];
      w.station_mac = dev_key[k].mac;
      w.read_index  = 4'($urandom);
      return w;
   endfunction

   function automatic req_type noise_word(cmd_type c);
      req_type w;
      w.command     = c;
      w.serial_high = {$urandom, $urandom};
      w.serial_low  = {$urandom, $urandom};
      w.station_mac = 48'({$urandom, $urandom});
      w.read_index  = 4'($urandom);
      return w;
   endfunction

   // empty serial: first character zero, optionally with garbage behind it
   function automatic req_type empty_word(cmd_type c, bit junk);
      req_type w;
      w = noise_word(c);
      w.serial_high[63:56] = 8'h00;
      if (!junk) begin
         w.serial_high = '0;
         w.serial_low  = '0;
      end
      return w;
   endfunction

   function automatic req_type read_word(int idx);
      req_type w;
      w = noise_word(CMD_READ);
      w.read_index = 4'(idx);
      return w;
   endfunction

   initial begin
      int      r;
      int      pick;
      bit      fill;
      cmd_type c;
      tracker = new();
      build_keys();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, empty serials, duplicates, full table, shifts
      send_word(read_word(0));
      send_word(key_word(CMD_LOOKUP, 0, 1'b0));
      send_word(key_word(CMD_REMOVE, 0, 1'b0));
      send_word(empty_word(CMD_ADD, 1'b0));
      send_word(empty_word(CMD_ADD, 1'b1));
      send_word(key_word(CMD_ADD, 2, 1'b0));
      send_word(key_word(CMD_ADD, 2, 1'b1));
      send_word(key_word(CMD_ADD, 0, 1'b0));
      send_word(key_word(CMD_ADD, 1, 1'b0));
      for (int k = 3; k < TABLE_DEPTH; k++) send_word(key_word(CMD_ADD, k, 1'b0));
      send_word(key_word(CMD_ADD, TABLE_DEPTH, 1'b0));
      send_word(key_word(CMD_LOOKUP, 1, 1'b1));
      send_word(read_word(15));
      send_word(key_word(CMD_REMOVE, 2, 1'b0));
      send_word(key_word(CMD_REMOVE, 15, 1'b0));
      send_word(read_word(14));
      wait_for_drain();

      // Random mix over a small device pool so that hits are common; the table
      // is pushed toward full and toward empty in alternate stretches.
      // The generation limit needs 2^32 - 1 changes and is out of reach here.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         no_idle = (n >= 250 && n < 320);
         fill    = ((n / 80) % 2 == 0);
         r = $urandom_range(0, 99);
         if (r < 20) begin
            c = CMD_LOOKUP;
         end else if (r < (fill ? 65 : 35)) begin
            c = CMD_ADD;
         end else if (r < 85) begin
            c = CMD_REMOVE;
         end else begin
            c = CMD_READ;
         end
         pick = $urandom_range(0, 99);
         if (pick < 88) begin
            send_word(key_word(c, $urandom_range(0, KEY_COUNT - 1), $urandom_range(0, 2) == 0));
         end else if (pick < 94) begin
            send_word(empty_word(c, $urandom_range(0, 1)));
         end else begin
            send_word(noise_word(c));
         end
         if (n % 150 == 149) wait_for_drain();
      end

      no_idle = 1'b0;
      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
